// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GMSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GMSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMSP_ASSERT(label, clk, rst, prop, msg)
`define GMSP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/gmsp_pkg.sv =====
`default_nettype none

package gmsp_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 3;
   localparam int unsigned CFG_W = 7;
   localparam int unsigned LEN_W = 12;
   localparam int unsigned REG_IDX_W = 1;

   localparam logic [LEN_W-1:0] DIST_MAX = 12'hFFF;
   localparam logic [CFG_W-1:0] DIM_RESET = 7'd5;

   localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_SEARCH
   } gmsp_state_type;

   typedef struct packed {
      logic seed;
      logic step;
      logic wr_valid;
      logic wr_bit;
   } gmsp_cell_ctl_type;

   typedef struct packed {
      logic busy;
      logic wr_valid;
      logic wr_bit;
   } gmsp_sweep_type;

endpackage

`default_nettype wire

// ===== rtl/gmsp_if.sv =====
`default_nettype none

interface gmsp_req_if;
   logic valid;
   logic ready;
   logic cell_open;
   logic last_cell;

   modport source (output valid, output cell_open, output last_cell, input ready);
   modport sink (input valid, input cell_open, input last_cell, output ready);
endinterface

interface gmsp_rsp_if import gmsp_pkg::*;
();
   logic valid;
   logic ready;
   logic reachable;
   logic [LEN_W-1:0] path_length;

   modport source (output valid, output reachable, output path_length, input ready);
   modport sink (input valid, input reachable, input path_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/gmsp_cell.sv =====
`default_nettype none

module gmsp_cell import gmsp_pkg::*; #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned ROW_IDX = 0,
   localparam int unsigned RW = $clog2(MAX_ROWS),
   localparam int unsigned CW = $clog2(MAX_COLS)
) (
   input  logic                clock,
   input  gmsp_cell_ctl_type   ctl,
   input  logic [RW-1:0]       wr_row,
   input  logic [CW-1:0]       wr_col,
   input  logic [RW-1:0]       last_row,
   input  logic [CW-1:0]       last_col,
   input  logic [MAX_COLS-1:0] col_mask,
   input  logic [MAX_COLS-1:0] reach_above,
   input  logic [MAX_COLS-1:0] reach_below,
   output logic [MAX_COLS-1:0] reach_out,
   output logic                hit
);

   localparam logic [MAX_COLS-1:0] SEED = (ROW_IDX == 0) ? MAX_COLS'(1) : '0;

   logic [MAX_COLS-1:0] open_ff;
   logic [MAX_COLS-1:0] open_in;
   logic [MAX_COLS-1:0] reach_ff;
   logic [MAX_COLS-1:0] reach_in;
   logic [MAX_COLS-1:0] neigh;
   logic                row_active;

   always_comb begin
      row_active = (RW'(ROW_IDX) <= last_row);
      neigh = {reach_ff[MAX_COLS-2:0], 1'b0} | {1'b0, reach_ff[MAX_COLS-1:1]} |
              reach_above | reach_below;
      reach_in = reach_ff | (neigh & open_ff & col_mask & {MAX_COLS{row_active}});
      open_in = open_ff;
      if (ctl.wr_valid && (wr_row == RW'(ROW_IDX))) begin
         open_in[wr_col] = ctl.wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      open_ff <= open_in;
      if (ctl.seed) begin
         reach_ff <= SEED;
      end else if (ctl.step) begin
         reach_ff <= reach_in;
      end
   end

   assign reach_out = reach_ff;
   assign hit = reach_ff[last_col] && (last_row == RW'(ROW_IDX));

endmodule

`default_nettype wire

// ===== rtl/gmsp_store.sv =====
`default_nettype none

module gmsp_store import gmsp_pkg::*; #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64,
   localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS,
   localparam int unsigned AW = $clog2(DEPTH),
   localparam int unsigned CNT_W = $clog2(DEPTH + 1),
   localparam int unsigned RW = $clog2(MAX_ROWS),
   localparam int unsigned CW = $clog2(MAX_COLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_en,
   input  logic             load_last,
   input  logic             load_bit,
   input  logic [CNT_W-1:0] cells,
   input  logic [CW-1:0]    last_col,
   output gmsp_sweep_type   sweep,
   output logic [RW-1:0]    wr_row,
   output logic [CW-1:0]    wr_col
);

   logic             mem_ff [DEPTH];
   logic             mem_we;
   logic [CNT_W-1:0] load_ptr_ff;
   logic [CNT_W-1:0] load_ptr_in;
   logic             active_ff;
   logic             active_in;
   logic [CNT_W-1:0] addr_ff;
   logic [CNT_W-1:0] addr_in;
   logic [RW-1:0]    row_ff;
   logic [RW-1:0]    row_in;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic             wr_valid_ff;
   logic [RW-1:0]    wr_row_ff;
   logic [CW-1:0]    wr_col_ff;
   logic             rd_ff;

   always_comb begin
      load_ptr_in = load_ptr_ff;
      mem_we = 1'b0;
      if (load_en) begin
         if (load_ptr_ff < cells) begin
            mem_we = 1'b1;
            load_ptr_in = load_ptr_ff + CNT_W'(1);
         end
         if (load_last) begin
            load_ptr_in = '0;
         end
      end

      active_in = active_ff;
      addr_in = addr_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (load_en && load_last) begin
         active_in = 1'b1;
         addr_in = '0;
         row_in = '0;
         col_in = '0;
      end else if (active_ff) begin
         if (addr_ff == cells - CNT_W'(1)) begin
            active_in = 1'b0;
         end
         addr_in = addr_ff + CNT_W'(1);
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         active_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         active_ff <= active_in;
         wr_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      row_ff <= row_in;
      col_ff <= col_in;
      wr_row_ff <= row_ff;
      wr_col_ff <= col_ff;
      rd_ff <= mem_ff[addr_ff[AW-1:0]];
      if (mem_we) begin
         mem_ff[load_ptr_ff[AW-1:0]] <= load_bit;
      end
   end

   assign sweep.busy = active_ff | wr_valid_ff;
   assign sweep.wr_valid = wr_valid_ff;
   assign sweep.wr_bit = rd_ff;
   assign wr_row = wr_row_ff;
   assign wr_col = wr_col_ff;

endmodule

`default_nettype wire

// ===== rtl/grid_maze_shortest_path.sv =====
// Loading takes one cell word per cycle while ready is high; a word without the last
// mark causes no result. After the last cell, a copy pass moves the maze from memory
// into the row cells, then the wavefront advances one step per cycle over the rows in
// use; path_length is the step count at the first hit, and 0 when unreachable.
// Synchronous reset clears control, the handshakes and both dimension registers to 5;
// the maze memory and the row cells are not cleared.
`default_nettype none
`include "assert_macros.svh"

module grid_maze_shortest_path import gmsp_pkg::*; #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   gmsp_req_if.sink           req_ch,
   gmsp_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned RW = $clog2(MAX_ROWS);
   localparam int unsigned CW = $clog2(MAX_COLS);
   localparam int unsigned RDW = $clog2(MAX_ROWS + 1);
   localparam int unsigned CDW = $clog2(MAX_COLS + 1);
   localparam int unsigned EXT_R = (RDW > CFG_W) ? RDW : CFG_W;
   localparam int unsigned EXT_C = (CDW > CFG_W) ? CDW : CFG_W;
   localparam int unsigned DW = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   logic [CFG_W-1:0]    rows_ff;
   logic [CFG_W-1:0]    rows_in;
   logic [CFG_W-1:0]    cols_ff;
   logic [CFG_W-1:0]    cols_in;
   logic [EXT_R-1:0]    rows_ext;
   logic [EXT_C-1:0]    cols_ext;
   logic [RDW-1:0]      rows_eff;
   logic [CDW-1:0]      cols_eff;
   logic [RW-1:0]       last_row;
   logic [CW-1:0]       last_col;
   logic [CNT_W-1:0]    cells;
   logic [MAX_COLS-1:0] col_mask;

   gmsp_state_type      state_ff;
   gmsp_state_type      state_in;
   logic [CNT_W-1:0]    d_ff;
   logic [CNT_W-1:0]    d_in;
   logic [DW-1:0]       d_ext;
   logic [LEN_W-1:0]    len_sat;
   logic                do_step;
   logic                rsp_load;
   logic                req_acc;
   logic                hit;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_reach_ff;
   logic                rsp_reach_in;
   logic [LEN_W-1:0]    rsp_len_ff;
   logic [LEN_W-1:0]    rsp_len_in;

   gmsp_sweep_type      sweep;
   gmsp_cell_ctl_type   cell_ctl;
   logic [RW-1:0]       wr_row;
   logic [CW-1:0]       wr_col;
   logic [MAX_ROWS-1:0] hit_vec;
   logic [MAX_COLS-1:0] reach_chain [MAX_ROWS+2];

   // Register file.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (psel && penable && pwrite) begin
         case (paddr[ADDR_W-1])
            REG_ROWS: rows_in = pwdata[CFG_W-1:0];
            REG_COLS: cols_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
      case (paddr[ADDR_W-1])
         REG_ROWS: prdata = DATA_W'(rows_ff);
         REG_COLS: prdata = DATA_W'(cols_ff);
         default: prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Dimensions in use, with out-of-range values clamped.
   always_comb begin
      rows_ext = EXT_R'(rows_ff);
      cols_ext = EXT_C'(cols_ff);
      if (rows_ext == '0) begin
         rows_eff = RDW'(1);
      end else if (rows_ext > EXT_R'(MAX_ROWS)) begin
         rows_eff = RDW'(MAX_ROWS);
      end else begin
         rows_eff = RDW'(rows_ext);
      end
      if (cols_ext == '0) begin
         cols_eff = CDW'(1);
      end else if (cols_ext > EXT_C'(MAX_COLS)) begin
         cols_eff = CDW'(MAX_COLS);
      end else begin
         cols_eff = CDW'(cols_ext);
      end
      last_row = RW'(rows_eff - RDW'(1));
      last_col = CW'(cols_eff - CDW'(1));
      cells = CNT_W'(rows_eff) * CNT_W'(cols_eff);
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (CDW'(j) < cols_eff);
      end
   end

   assign req_acc = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_LOAD);
   assign hit = |hit_vec;

   always_comb begin
      d_ext = DW'(d_ff);
      len_sat = (d_ext > DW'(DIST_MAX)) ? DIST_MAX : LEN_W'(d_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         d_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else begin
         state_ff <= state_in;
         d_ff <= d_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reach_ff <= rsp_reach_in;
      rsp_len_ff <= rsp_len_in;
   end

   always_comb begin
      state_in = state_ff;
      d_in = d_ff;
      do_step = 1'b0;
      rsp_load = 1'b0;
      rsp_reach_in = rsp_reach_ff;
      rsp_len_in = rsp_len_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_ch.last_cell) begin
               state_in = ST_SWEEP;
               d_in = '0;
            end
         end
         ST_SWEEP: begin
            if (!sweep.busy) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit || (d_ff == cells - CNT_W'(1))) begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_load = 1'b1;
                  rsp_reach_in = hit;
                  rsp_len_in = hit ? len_sat : '0;
                  state_in = ST_LOAD;
               end
            end else begin
               do_step = 1'b1;
               d_in = d_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_LOAD;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.reachable = rsp_reach_ff;
   assign rsp_ch.path_length = rsp_len_ff;

   gmsp_store #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .load_en   (req_acc),
      .load_last (req_ch.last_cell),
      .load_bit  (req_ch.cell_open),
      .cells     (cells),
      .last_col  (last_col),
      .sweep     (sweep),
      .wr_row    (wr_row),
      .wr_col    (wr_col)
   );

   assign cell_ctl.seed = req_acc && req_ch.last_cell;
   assign cell_ctl.step = do_step;
   assign cell_ctl.wr_valid = sweep.wr_valid;
   assign cell_ctl.wr_bit = sweep.wr_bit;

   assign reach_chain[0] = '0;
   assign reach_chain[MAX_ROWS+1] = '0;

   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      gmsp_cell #(
         .MAX_ROWS (MAX_ROWS),
         .MAX_COLS (MAX_COLS),
         .ROW_IDX  (r)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .wr_row      (wr_row),
         .wr_col      (wr_col),
         .last_row    (last_row),
         .last_col    (last_col),
         .col_mask    (col_mask),
         .reach_above (reach_chain[r]),
         .reach_below (reach_chain[r+2]),
         .reach_out   (reach_chain[r+1]),
         .hit         (hit_vec[r])
      );
   end

   `GMSP_ASSERT(a_last_starts_copy, clock, reset, req_acc && req_ch.last_cell |=> state_ff == ST_SWEEP, "last cell did not start the copy pass")
   `GMSP_ASSERT(a_copy_in_state, clock, reset, sweep.busy |-> state_ff == ST_SWEEP, "copy pass running outside its state")
   `GMSP_ASSERT(a_rsp_from_search, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SEARCH, "result raised outside the search")
   `GMSP_ASSERT(a_step_bound, clock, reset, state_ff == ST_SEARCH |-> d_ff <= cells - CNT_W'(1), "search ran past the cell count")
   `GMSP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid_ff, "result valid survived reset")

endmodule

`default_nettype wire
